// ===== rtl/sitdt_pkg.sv =====
// sitdt_pkg: shared types and constants for the signed integer to decimal text block
// character codes, digit width, emitter state encoding and the converter status bundle
// no dependencies
`default_nettype none

package sitdt_pkg;

  // character and digit widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // highest value of one decimal digit
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // bcd digit at or above this value gets plus three before the shift
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

  // character emitter states
  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SKIP,
    EM_SIGN,
    EM_DIGIT
  } emit_state_t;

  // converter status toward the emitter and the input side
  typedef struct packed {
    logic busy;  // shifting bits of the magnitude
    logic done;  // one-cycle pulse, bcd result is final
    logic neg;   // input value was negative
  } dbl_stat_t;

endpackage : sitdt_pkg

`default_nettype wire

// ===== rtl/sitdt_dabble.sv =====
// sitdt_dabble: bit-serial binary to bcd converter (shift and add three)
// one magnitude bit enters the bcd shift register per cycle
// depends on sitdt_pkg
`default_nettype none

module sitdt_dabble
  import sitdt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned NDIG        = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        start_neg,
  input  wire logic [VALUE_WIDTH-1:0]      start_mag,
  output      dbl_stat_t                   stat,
  output      logic [NDIG*DIGIT_W-1:0]     bcd
);

  localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH);
  localparam int unsigned BCD_W  = NDIG * DIGIT_W;

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       adj;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic                   neg_r, neg_nxt;

  // add three to every digit of five or more, digits are independent
  always_comb begin
    for (int i = 0; i < int'(NDIG); i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // next values: load on start, then one shift per cycle
  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      mag_nxt  = start_mag;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      neg_nxt  = start_neg;
    end else if (busy_r) begin
      bcd_nxt = {adj[BCD_W-2:0], mag_r[VALUE_WIDTH-1]};
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(VALUE_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.neg  = neg_r;
  assign bcd       = bcd_r;

endmodule : sitdt_dabble

`default_nettype wire

// ===== rtl/sitdt_emit.sv =====
// sitdt_emit: character emitter, drops leading zeros and sends sign and digits
// one bcd digit leaves the shift register per cycle into the output register while the output is not stalled
// depends on sitdt_pkg
`default_nettype none

module sitdt_emit
  import sitdt_pkg::*;
#(
  parameter int unsigned NDIG = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dbl_stat_t                 stat,
  input  wire logic [NDIG*DIGIT_W-1:0]   bcd,
  output      logic                      idle,
  output      logic                      out_tvalid,
  input  wire logic                      out_tready,
  output      logic [CHAR_W-1:0]         out_tdata,
  output      logic                      out_tlast
);

  localparam int unsigned BCD_W = NDIG * DIGIT_W;
  localparam int unsigned REM_W = $clog2(NDIG + 1);

  emit_state_t        state_r, state_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               neg_r, neg_nxt;
  logic               vld_r, vld_nxt;
  logic [CHAR_W-1:0]  chr_r, chr_nxt;
  logic               lst_r, lst_nxt;
  logic [DIGIT_W-1:0] top_digit;
  logic               slot_free;
  logic               one_left;

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];
  assign slot_free = !vld_r || out_tready;
  assign one_left  = (rem_r == REM_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EM_IDLE: begin
        if (stat.done) begin
          state_nxt = EM_SKIP;
        end
      end
      EM_SKIP: begin
        if (top_digit != '0 || one_left) begin
          state_nxt = neg_r ? EM_SIGN : EM_DIGIT;
        end
      end
      EM_SIGN: begin
        if (slot_free) begin
          state_nxt = EM_DIGIT;
        end
      end
      EM_DIGIT: begin
        if (slot_free && one_left) begin
          state_nxt = EM_IDLE;
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  // datapath and output register next values
  always_comb begin
    bcd_nxt = bcd_r;
    rem_nxt = rem_r;
    neg_nxt = neg_r;
    vld_nxt = vld_r && !out_tready;
    chr_nxt = chr_r;
    lst_nxt = lst_r;
    case (state_r)
      EM_IDLE: begin
        if (stat.done) begin
          bcd_nxt = bcd;
          rem_nxt = REM_W'(NDIG);
          neg_nxt = stat.neg;
        end
      end
      EM_SKIP: begin
        if (top_digit == '0 && !one_left) begin
          bcd_nxt = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          rem_nxt = rem_r - 1'b1;
        end
      end
      EM_SIGN: begin
        if (slot_free) begin
          vld_nxt = 1'b1;
          chr_nxt = CH_MINUS;
          lst_nxt = 1'b0;
        end
      end
      EM_DIGIT: begin
        if (slot_free) begin
          vld_nxt = 1'b1;
          chr_nxt = CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
          lst_nxt = one_left;
          bcd_nxt = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          rem_nxt = rem_r - 1'b1;
        end
      end
      default: begin
        vld_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    chr_r <= chr_nxt;
    lst_r <= lst_nxt;
  end

  assign idle       = (state_r == EM_IDLE);
  assign out_tvalid = vld_r;
  assign out_tdata  = chr_r;
  assign out_tlast  = lst_r;

endmodule : sitdt_emit

`default_nettype wire

// ===== rtl/signed_int_to_decimal_text.sv =====
// signed_int_to_decimal_text: top level, signed integer in, decimal ascii characters out
// instantiates sitdt_dabble (bit-serial bcd conversion) and sitdt_emit (character output)
// depends on sitdt_pkg
//
//  channel  direction  tdata                          tlast
//  in_      slave      [VALUE_WIDTH-1:0] value        -
//  out_     master     [7:0] char_code                last character of the value
//
// an accepted value shifts one bit per cycle through the bcd converter, whose done pulse is
// registered before the emitter sees it; the emitter drops one leading zero digit per cycle,
// then sends the sign of a negative value and one character per cycle while the output is
// not stalled; the next value is taken only once the converter is done and the emitter is
// idle again; a stalled output holds its character; reset clears control

`default_nettype none

module signed_int_to_decimal_text
  import sitdt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0] in_tdata,   // [VALUE_WIDTH-1:0] value
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [CHAR_W-1:0]               out_tdata,  // [7:0] char_code
  output      logic                            out_tlast
);

  // decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
  localparam int unsigned NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned BCD_W = NDIG * DIGIT_W;

  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;
  logic                   in_xfer;
  logic                   em_idle;
  dbl_stat_t              dbl_stat;
  logic [BCD_W-1:0]       dbl_bcd;

  // magnitude as an unsigned value, so the most negative input needs no extra bit
  assign value   = in_tdata[VALUE_WIDTH-1:0];
  assign neg     = value[VALUE_WIDTH-1];
  assign mag     = neg ? (~value + 1'b1) : value;

  // one value in flight at a time
  assign in_tready = !dbl_stat.busy && !dbl_stat.done && em_idle;
  assign in_xfer   = in_tvalid && in_tready;

  // bit-serial conversion
  sitdt_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_dabble (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer),
    .start_neg (neg),
    .start_mag (mag),
    .stat      (dbl_stat),
    .bcd       (dbl_bcd)
  );

  // character output
  sitdt_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (dbl_stat),
    .bcd        (dbl_bcd),
    .idle       (em_idle),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // an accepted value blocks the input until its run is done
  a_in_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input accepted while a conversion is running");

  // a minus sign is never the last character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata == CH_MINUS) |-> !out_tlast)
    else $error("minus sign flagged as last character");

  // only a sign or a decimal digit leaves the block
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == CH_MINUS ||
                    (out_tdata >= CH_ZERO &&
                     out_tdata <= CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_MAX})))
    else $error("output character is neither sign nor digit");

endmodule : signed_int_to_decimal_text

`default_nettype wire
